// ===== rtl/tape_transport_motion_model_assert.svh =====
// Assertion macros used by the checker file of the tape transport motion model.
`ifndef TAPE_TRANSPORT_MOTION_MODEL_ASSERT_SVH
`define TAPE_TRANSPORT_MOTION_MODEL_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define TTM_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tape transport check failed");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define TTM_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tape transport check failed");

`endif

// ===== rtl/ttm_pkg.sv =====
// Shared types and constants of the tape transport motion model.
`default_nettype none

package ttm_pkg;

   localparam int POS_BITS      = 48;
   localparam int RAMP_BITS     = 32;
   localparam int TIME_BITS_DEF = 48;

   localparam logic [31:0] STOP_RAMP_RST  = 32'd150000000;
   localparam logic [31:0] START_RAMP_RST = 32'd200000000;
   localparam logic [31:0] TURN_RAMP_RST  = 32'd150000000;

   typedef enum logic [1:0] {
      MOT_STOPPED = 2'd0,
      MOT_ACCEL   = 2'd1,
      MOT_CRUISE  = 2'd2,
      MOT_DECEL   = 2'd3
   } motion_type;

   localparam logic [2:0] ACT_QUERY   = 3'd0;
   localparam logic [2:0] ACT_COMMAND = 3'd1;
   localparam logic [2:0] ACT_EZ_STOP = 3'd2;
   localparam logic [2:0] ACT_END_SEG = 3'd3;
   localparam logic [2:0] ACT_PARK    = 3'd4;

   localparam logic [1:0] CSR_STOP_RAMP  = 2'd0;
   localparam logic [1:0] CSR_START_RAMP = 2'd1;
   localparam logic [1:0] CSR_TURN_RAMP  = 2'd2;

   // operands of one (a*b)/d job for the serial unit
   typedef struct packed {
      logic [31:0] a;
      logic [31:0] b;
      logic [32:0] d;
   } md_req_type;

endpackage

`default_nettype wire

// ===== rtl/ttm_muldiv.sv =====
// Bit-serial multiply then restoring divide: q = (a*b)/d, one bit per cycle.
`default_nettype none

module ttm_muldiv (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire ttm_pkg::md_req_type req,
   output logic                     done,
   output logic [31:0]              q
);

   localparam logic [5:0] MUL_LAST = 6'd31;
   localparam logic [5:0] DIV_LAST = 6'd63;

   typedef enum logic [2:0] {
      MD_IDLE = 3'b001,
      MD_MUL  = 3'b010,
      MD_DIV  = 3'b100
   } md_state_type;

   md_state_type state_ff;
   logic [5:0]   cnt_ff;
   logic [31:0]  a_ff;
   logic [32:0]  d_ff;
   logic [31:0]  hi_ff;
   logic [31:0]  lo_ff;
   logic [32:0]  rem_ff;
   logic         done_ff;

   logic [32:0]  sum;
   logic [63:0]  dvd;
   logic [33:0]  trial;
   logic [33:0]  diff;
   logic         ge;

   // shift-add step and restoring-divide step
   always_comb begin
      sum   = {1'b0, hi_ff} + (lo_ff[0] ? {1'b0, a_ff} : 33'd0);
      dvd   = {hi_ff, lo_ff};
      trial = {rem_ff, dvd[63]};
      ge    = trial >= {1'b0, d_ff};
      diff  = trial - {1'b0, d_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MD_IDLE;
         cnt_ff   <= '0;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         case (state_ff)
            MD_IDLE: begin
               if (start) begin
                  a_ff     <= req.a;
                  d_ff     <= req.d;
                  hi_ff    <= '0;
                  lo_ff    <= req.b;
                  cnt_ff   <= '0;
                  state_ff <= MD_MUL;
               end
            end
            MD_MUL: begin
               hi_ff  <= sum[32:1];
               lo_ff  <= {sum[0], lo_ff[31:1]};
               cnt_ff <= cnt_ff + 6'd1;
               if (cnt_ff == MUL_LAST) begin
                  cnt_ff   <= '0;
                  rem_ff   <= '0;
                  state_ff <= MD_DIV;
               end
            end
            MD_DIV: begin
               rem_ff <= ge ? diff[32:0] : trial[32:0];
               hi_ff  <= dvd[62:31];
               lo_ff  <= {dvd[30:0], ge};
               cnt_ff <= cnt_ff + 6'd1;
               if (cnt_ff == DIV_LAST) begin
                  done_ff  <= 1'b1;
                  state_ff <= MD_IDLE;
               end
            end
            default: state_ff <= MD_IDLE;
         endcase
      end
   end

   assign done = done_ff;
   assign q    = lo_ff;

endmodule

`default_nettype wire

// ===== rtl/tape_transport_motion_model.sv =====
// Top level of the tape transport motion model: sequencer, state and result register.
//
//   channel | ports | direction | handshake
//   req     | req_* | in        | req_valid / req_ready
//   rsp     | rsp_* | out       | rsp_valid / rsp_ready
//   csr     | csr_* | in        | csr_valid / csr_ready (always ready)
//
// One transaction at a time. Each (a*b)/d job on the bit-serial unit holds a step
// while it is issued, multiplies, divides and hands over the quotient. A query, end
// segment, park or any other transaction that starts no ramp runs one job; a command
// or end zone stop that starts a ramp runs four jobs.
// Reset is synchronous and needs no clearing pass; csr writes are taken at once.
// A result held by rsp_ready low does not block acceptance of the next req transaction;
// that one waits in its last step until the held result is taken.
`default_nettype none

module tape_transport_motion_model #(
   parameter int TIME_BITS = ttm_pkg::TIME_BITS_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [2:0]         req_action,
   input  wire logic [47:0]        req_time_ns,
   input  wire logic               req_go,
   input  wire logic               req_reverse,
   input  wire logic signed [47:0] req_park_position,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic signed [47:0]      rsp_position,
   output logic [47:0]             rsp_segment_end,
   output logic                    rsp_segment_open,
   output logic [1:0]              rsp_motion_state,
   output logic                    rsp_moving_reverse,
   output logic                    rsp_go_latched,
   output logic                    rsp_rev_latched,
   output logic                    rsp_turn_pending,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [1:0]         csr_index,
   input  wire logic [31:0]        csr_data
);

   localparam int PB = ttm_pkg::POS_BITS;

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_DECIDE = 7'b0000010,
      ST_POS0   = 7'b0000100,
      ST_SCALE  = 7'b0001000,
      ST_DIST   = 7'b0010000,
      ST_OUTPOS = 7'b0100000,
      ST_RESP   = 7'b1000000
   } seq_state_type;

   typedef enum logic [1:0] {
      OP_NONE  = 2'd0,
      OP_DECEL = 2'd1,
      OP_ACCEL = 2'd2
   } op_type;

   // elapsed time a-b, zero when negative modulo 2^TIME_BITS
   function automatic logic [TIME_BITS-1:0] ahead_f(input logic [TIME_BITS-1:0] a,
                                                    input logic [TIME_BITS-1:0] b);
      logic [TIME_BITS-1:0] d;
      d = a - b;
      return d[TIME_BITS-1] ? '0 : d;
   endfunction

   function automatic logic [31:0] clamp_f(input logic [TIME_BITS-1:0] d,
                                           input logic [31:0] r);
      if (d > {{(TIME_BITS-32){1'b0}}, r}) return r;
      return d[31:0];
   endfunction

   function automatic logic [PB-1:0] move_f(input logic [PB-1:0] pos,
                                            input logic [PB-1:0] delta,
                                            input logic rev);
      return rev ? pos - delta : pos + delta;
   endfunction

   // configuration
   logic [31:0] stop_ramp_ff, start_ramp_ff, turn_ramp_ff;

   // motion state
   ttm_pkg::motion_type  motion_ff;
   logic                 dir_ff;
   logic [TIME_BITS-1:0] ref_time_ff;
   logic [PB-1:0]        ref_pos_ff;
   logic [31:0]          ramp_len_ff;
   logic                 pend_acc_ff, pend_rev_ff;
   logic [31:0]          pend_ramp_ff;
   logic                 go_ff, rev_ff;

   // current transaction
   seq_state_type        state_ff;
   logic [2:0]           act_ff;
   logic [TIME_BITS-1:0] t_ff;
   logic                 in_go_ff, in_rev_ff;
   logic [PB-1:0]        park_ff;
   op_type               op_ff;
   logic [31:0]          ramp_ff;
   logic [PB-1:0]        p0_ff;
   logic [31:0]          x_ff;
   logic                 issued_ff;

   // result register
   logic                 rsp_valid_ff;
   logic [PB-1:0]        rsp_pos_ff;
   logic [47:0]          rsp_seg_ff;
   logic                 rsp_open_ff;
   logic [1:0]           rsp_mot_ff;
   logic                 rsp_dir_ff, rsp_go_ff, rsp_rev_ff, rsp_pend_ff;

   // serial unit hookup
   ttm_pkg::md_req_type  md_req;
   logic                 md_start, md_done;
   logic [31:0]          md_q;

   logic [31:0]          rl_now;
   logic [31:0]          dtc_now;
   logic [63:0]          cruise64;
   logic [PB-1:0]        pos_now;
   logic [63:0]          t64;
   logic [TIME_BITS-1:0] x_t;
   logic [TIME_BITS-1:0] seg_t;
   logic [63:0]          seg64;
   logic                 run_dir;
   op_type               op_in;
   logic                 work_state;

   assign t64 = {16'b0, req_time_ns};
   assign x_t = {{(TIME_BITS-32){1'b0}}, x_ff};
   assign run_dir = motion_ff == ttm_pkg::MOT_ACCEL || motion_ff == ttm_pkg::MOT_CRUISE;

   // clamped time into the current ramp and position (from the quotient on a ramp)
   always_comb begin
      rl_now   = (ramp_len_ff == 32'd0) ? 32'd1 : ramp_len_ff;
      cruise64 = 64'(ahead_f(t_ff, ref_time_ff));
      case (motion_ff)
         ttm_pkg::MOT_ACCEL: dtc_now = clamp_f(ahead_f(t_ff, ref_time_ff), rl_now);
         ttm_pkg::MOT_DECEL: dtc_now = clamp_f(ahead_f(ref_time_ff, t_ff), rl_now);
         default:            dtc_now = '0;
      endcase
      case (motion_ff)
         ttm_pkg::MOT_ACCEL:  pos_now = move_f(ref_pos_ff, {16'b0, md_q}, dir_ff);
         ttm_pkg::MOT_CRUISE: pos_now = move_f(ref_pos_ff, cruise64[PB-1:0], dir_ff);
         ttm_pkg::MOT_DECEL:  pos_now = move_f(ref_pos_ff, {16'b0, md_q}, !dir_ff);
         default:             pos_now = ref_pos_ff;
      endcase
   end

   // which ramp the transaction starts, judged on the state before it
   always_comb begin
      op_in = OP_NONE;
      if (((act_ff == ttm_pkg::ACT_COMMAND) && (!in_go_ff || in_rev_ff != dir_ff)) ||
          (act_ff == ttm_pkg::ACT_EZ_STOP)) begin
         if (run_dir) op_in = OP_DECEL;
      end
      if (act_ff == ttm_pkg::ACT_COMMAND && in_go_ff &&
          (motion_ff == ttm_pkg::MOT_STOPPED ||
           (motion_ff == ttm_pkg::MOT_DECEL && in_rev_ff == dir_ff)))
         op_in = OP_ACCEL;
   end

   // operands per step
   always_comb begin
      work_state = state_ff == ST_POS0 || state_ff == ST_SCALE ||
                   state_ff == ST_DIST || state_ff == ST_OUTPOS;
      md_start   = work_state && !issued_ff;
      case (state_ff)
         ST_SCALE: md_req = '{a: dtc_now, b: ramp_ff, d: {1'b0, rl_now}};
         ST_DIST:  md_req = '{a: x_ff, b: x_ff, d: {ramp_ff, 1'b0}};
         default:  md_req = '{a: dtc_now, b: dtc_now, d: {rl_now, 1'b0}};
      endcase
      case (motion_ff)
         ttm_pkg::MOT_ACCEL: seg_t = ref_time_ff + {{(TIME_BITS-32){1'b0}}, rl_now};
         default:            seg_t = ref_time_ff;
      endcase
      seg64 = 64'(seg_t);
   end

   ttm_muldiv u_md (
      .clock (clock),
      .reset (reset),
      .start (md_start),
      .req   (md_req),
      .done  (md_done),
      .q     (md_q)
   );

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         stop_ramp_ff  <= ttm_pkg::STOP_RAMP_RST;
         start_ramp_ff <= ttm_pkg::START_RAMP_RST;
         turn_ramp_ff  <= ttm_pkg::TURN_RAMP_RST;
      end else if (csr_valid) begin
         case (csr_index)
            ttm_pkg::CSR_STOP_RAMP:  stop_ramp_ff  <= csr_data;
            ttm_pkg::CSR_START_RAMP: start_ramp_ff <= csr_data;
            ttm_pkg::CSR_TURN_RAMP:  turn_ramp_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // sequencer and motion state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         issued_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         motion_ff    <= ttm_pkg::MOT_STOPPED;
         dir_ff       <= 1'b0;
         ref_time_ff  <= '0;
         ref_pos_ff   <= '0;
         ramp_len_ff  <= '0;
         pend_acc_ff  <= 1'b0;
         pend_rev_ff  <= 1'b0;
         pend_ramp_ff <= '0;
         go_ff        <= 1'b0;
         rev_ff       <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
         if (md_start) issued_ff <= 1'b1;
         if (md_done)  issued_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  act_ff    <= req_action;
                  t_ff      <= t64[TIME_BITS-1:0];
                  in_go_ff  <= req_go;
                  in_rev_ff <= req_reverse;
                  park_ff   <= req_park_position;
                  state_ff  <= ST_DECIDE;
               end
            end
            ST_DECIDE: begin
               op_ff    <= op_in;
               ramp_ff  <= (op_in == OP_DECEL) ?
                           ((stop_ramp_ff == 32'd0) ? 32'd1 : stop_ramp_ff) :
                           ((start_ramp_ff == 32'd0) ? 32'd1 : start_ramp_ff);
               state_ff <= (op_in == OP_NONE) ? ST_OUTPOS : ST_POS0;
               case (act_ff)
                  ttm_pkg::ACT_COMMAND: begin
                     go_ff  <= in_go_ff;
                     rev_ff <= in_rev_ff;
                     if (!in_go_ff) begin
                        pend_acc_ff <= 1'b0;
                     end else if (motion_ff == ttm_pkg::MOT_DECEL && in_rev_ff == dir_ff) begin
                        pend_acc_ff <= 1'b0;
                     end else if (motion_ff != ttm_pkg::MOT_STOPPED && in_rev_ff != dir_ff) begin
                        pend_acc_ff  <= 1'b1;
                        pend_rev_ff  <= in_rev_ff;
                        pend_ramp_ff <= turn_ramp_ff;
                     end
                  end
                  ttm_pkg::ACT_EZ_STOP: begin
                     go_ff       <= 1'b0;
                     pend_acc_ff <= 1'b0;
                  end
                  ttm_pkg::ACT_END_SEG: begin
                     if (motion_ff == ttm_pkg::MOT_ACCEL) begin
                        ref_pos_ff  <= move_f(ref_pos_ff, {17'b0, rl_now[31:1]}, dir_ff);
                        ref_time_ff <= ref_time_ff + {{(TIME_BITS-32){1'b0}}, rl_now};
                        motion_ff   <= ttm_pkg::MOT_CRUISE;
                     end else if (motion_ff == ttm_pkg::MOT_DECEL) begin
                        if (pend_acc_ff) begin
                           pend_acc_ff <= 1'b0;
                           motion_ff   <= ttm_pkg::MOT_ACCEL;
                           dir_ff      <= pend_rev_ff;
                           ramp_len_ff <= (pend_ramp_ff == 32'd0) ? 32'd1 : pend_ramp_ff;
                        end else begin
                           motion_ff <= ttm_pkg::MOT_STOPPED;
                        end
                     end
                  end
                  ttm_pkg::ACT_PARK: begin
                     motion_ff   <= ttm_pkg::MOT_STOPPED;
                     ref_pos_ff  <= park_ff;
                     ref_time_ff <= '0;
                     go_ff       <= 1'b0;
                     rev_ff      <= 1'b0;
                     pend_acc_ff <= 1'b0;
                  end
                  default: ;
               endcase
            end
            // position at the action time before the ramp change
            ST_POS0: begin
               if (md_done) begin
                  p0_ff    <= pos_now;
                  state_ff <= ST_SCALE;
               end
            end
            // time into the new ramp that matches the present speed
            ST_SCALE: begin
               if (md_done) begin
                  if (motion_ff == ttm_pkg::MOT_CRUISE)       x_ff <= ramp_ff;
                  else if (motion_ff == ttm_pkg::MOT_STOPPED) x_ff <= '0;
                  else                                        x_ff <= md_q;
                  state_ff <= ST_DIST;
               end
            end
            // ramp distance and the new segment
            ST_DIST: begin
               if (md_done) begin
                  ramp_len_ff <= ramp_ff;
                  if (op_ff == OP_DECEL) begin
                     motion_ff   <= ttm_pkg::MOT_DECEL;
                     ref_time_ff <= t_ff + x_t;
                     ref_pos_ff  <= move_f(p0_ff, {16'b0, md_q}, dir_ff);
                  end else begin
                     motion_ff   <= ttm_pkg::MOT_ACCEL;
                     dir_ff      <= in_rev_ff;
                     ref_time_ff <= t_ff - x_t;
                     ref_pos_ff  <= move_f(p0_ff, {16'b0, md_q}, !in_rev_ff);
                  end
                  state_ff <= ST_OUTPOS;
               end
            end
            // reported position waits in p0 while a held result is still out
            ST_OUTPOS: begin
               if (md_done) begin
                  p0_ff    <= pos_now;
                  state_ff <= ST_RESP;
               end
            end
            ST_RESP: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_pos_ff   <= p0_ff;
                  rsp_seg_ff   <= run_dir && motion_ff == ttm_pkg::MOT_CRUISE ? '1 :
                                  (motion_ff == ttm_pkg::MOT_STOPPED ? '1 : seg64[47:0]);
                  rsp_open_ff  <= motion_ff == ttm_pkg::MOT_STOPPED ||
                                  motion_ff == ttm_pkg::MOT_CRUISE;
                  rsp_mot_ff   <= motion_ff;
                  rsp_dir_ff   <= dir_ff;
                  rsp_go_ff    <= go_ff;
                  rsp_rev_ff   <= rev_ff;
                  rsp_pend_ff  <= pend_acc_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_ready          = state_ff == ST_IDLE;
   assign csr_ready          = 1'b1;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_position       = $signed(rsp_pos_ff);
   assign rsp_segment_end    = rsp_seg_ff;
   assign rsp_segment_open   = rsp_open_ff;
   assign rsp_motion_state   = rsp_mot_ff;
   assign rsp_moving_reverse = rsp_dir_ff;
   assign rsp_go_latched     = rsp_go_ff;
   assign rsp_rev_latched    = rsp_rev_ff;
   assign rsp_turn_pending   = rsp_pend_ff;

endmodule

`default_nettype wire

// ===== rtl/ttm_checker.sv =====
// Port-level checks of the tape transport motion model and their bind.
`default_nettype none
`include "tape_transport_motion_model_assert.svh"

module ttm_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_valid,
   input wire logic               req_ready,
   input wire logic               rsp_valid,
   input wire logic               rsp_ready,
   input wire logic [47:0]        rsp_segment_end,
   input wire logic               rsp_segment_open,
   input wire logic [1:0]         rsp_motion_state,
   input wire logic signed [47:0] rsp_position
);

   logic open_code;

   // stopped or cruising has no scheduled end
   assign open_code = rsp_motion_state == ttm_pkg::MOT_STOPPED ||
                      rsp_motion_state == ttm_pkg::MOT_CRUISE;

   // a held result keeps its position
   `TTM_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_position))

   // open segment flag follows the motion code
   `TTM_ASSERT_IMP(a_open_code, clock, reset, rsp_valid, rsp_segment_open == open_code)

   // an open segment reports no end time
   `TTM_ASSERT_IMP(a_open_end, clock, reset, rsp_valid && rsp_segment_open, rsp_segment_end == '1)

   // one transaction at a time
   `TTM_ASSERT_NXT(a_busy, clock, reset, req_valid && req_ready, !req_ready)

endmodule

bind tape_transport_motion_model ttm_checker u_ttm_checker (.*);

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for the tape transport motion model.
`timescale 1ns / 100ps
`default_nettype none

module tb_top;

   typedef struct packed {
      logic [2:0]         action;
      logic [47:0]        time_ns;
      logic               go;
      logic               reverse;
      logic signed [47:0] park_position;
   } motion_req_type;

   typedef struct packed {
      logic [47:0] position;
      logic [47:0] segment_end;
      logic        segment_open;
      logic [1:0]  motion_state;
      logic        moving_reverse;
      logic        go_latched;
      logic        rev_latched;
      logic        turn_pending;
   } motion_rsp_type;

   localparam logic [47:0] MASK48 = 48'hFFFF_FFFF_FFFF;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [2:0] req_action = ttm_pkg::ACT_QUERY;
   logic [47:0] req_time_ns = '0;
   logic req_go = 1'b0;
   logic req_reverse = 1'b0;
   logic signed [47:0] req_park_position = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [47:0] rsp_position;
   logic [47:0] rsp_segment_end;
   logic rsp_segment_open;
   logic [1:0] rsp_motion_state;
   logic rsp_moving_reverse, rsp_go_latched, rsp_rev_latched, rsp_turn_pending;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [1:0] csr_index = ttm_pkg::CSR_STOP_RAMP;
   logic [31:0] csr_data = '0;

   tape_transport_motion_model i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_action(req_action),
      .req_time_ns(req_time_ns), .req_go(req_go), .req_reverse(req_reverse),
      .req_park_position(req_park_position),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_position(rsp_position),
      .rsp_segment_end(rsp_segment_end), .rsp_segment_open(rsp_segment_open),
      .rsp_motion_state(rsp_motion_state), .rsp_moving_reverse(rsp_moving_reverse),
      .rsp_go_latched(rsp_go_latched), .rsp_rev_latched(rsp_rev_latched),
      .rsp_turn_pending(rsp_turn_pending),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   // transport model state
   logic [31:0]         stop_ramp, start_ramp, turn_ramp;
   ttm_pkg::motion_type mot;
   logic                dir_rev, pend_accel, pend_rev, go_bit, rev_bit;
   logic [63:0]         seg_time, seg_pos, ramp_len, pend_ramp;

   motion_req_type pending_reqs[$];
   motion_rsp_type expected_rsps[$];
   int unsigned send_idle_pct = 35, recv_idle_pct = 49;
   int unsigned errors = 0, rsp_count = 0, cfg_writes = 0;
   logic        hold_sender = 1'b0;
   logic        busy = 1'b0;

   function automatic logic [63:0] time_ahead(logic [63:0] a, logic [63:0] b);
      logic [63:0] d;
      d = (a - b) & MASK48;
      return d[47] ? 64'd0 : d;
   endfunction

   function automatic logic [63:0] nz(logic [63:0] r);
      return (r == 64'd0) ? 64'd1 : r;
   endfunction

   function automatic logic [63:0] ramp_dist(logic [63:0] dt, logic [63:0] r);
      return (dt * dt) / (r + r);
   endfunction

   function automatic logic [63:0] shift_pos(logic [63:0] p, logic [63:0] d, logic rev);
      return (rev ? p - d : p + d) & MASK48;
   endfunction

   function automatic logic [63:0] pos_at(logic [63:0] t);
      logic [63:0] r, dt;
      r = nz(ramp_len);
      case (mot)
         ttm_pkg::MOT_ACCEL: begin
            dt = time_ahead(t, seg_time);
            if (dt > r) dt = r;
            return shift_pos(seg_pos, ramp_dist(dt, r), dir_rev);
         end
         ttm_pkg::MOT_CRUISE: return shift_pos(seg_pos, time_ahead(t, seg_time), dir_rev);
         ttm_pkg::MOT_DECEL: begin
            dt = time_ahead(seg_time, t);
            if (dt > r) dt = r;
            return shift_pos(seg_pos, ramp_dist(dt, r), !dir_rev);
         end
         default: return seg_pos;
      endcase
   endfunction

   task automatic begin_stop(logic [63:0] t, logic [63:0] ramp);
      logic [63:0] p, rest, dt, r;
      p = pos_at(t);
      r = nz(ramp_len);
      ramp = nz(ramp);
      if (mot == ttm_pkg::MOT_CRUISE) rest = ramp;
      else if (mot == ttm_pkg::MOT_ACCEL) begin
         dt = time_ahead(t, seg_time);
         if (dt > r) dt = r;
         rest = (dt * ramp) / r;
      end else return;
      mot = ttm_pkg::MOT_DECEL;
      seg_time = (t + rest) & MASK48;
      seg_pos = shift_pos(p, ramp_dist(rest, ramp), dir_rev);
      ramp_len = ramp;
   endtask

   task automatic begin_run(logic [63:0] t, logic rev, logic [63:0] ramp);
      logic [63:0] p, dt, d, r;
      p = pos_at(t);
      r = nz(ramp_len);
      ramp = nz(ramp);
      if (mot == ttm_pkg::MOT_STOPPED) dt = 64'd0;
      else if (mot == ttm_pkg::MOT_DECEL && rev == dir_rev) begin
         d = time_ahead(seg_time, t);
         if (d > r) d = r;
         dt = (d * ramp) / r;
      end else return;
      mot = ttm_pkg::MOT_ACCEL;
      dir_rev = rev;
      ramp_len = ramp;
      seg_time = (t - dt) & MASK48;
      seg_pos = shift_pos(p, ramp_dist(dt, ramp), !rev);
   endtask

   task automatic arm_turn(logic rev);
      pend_accel = 1'b1;
      pend_rev = rev;
      pend_ramp = {32'd0, turn_ramp};
   endtask

   // apply one transaction to the model and return the expected result
   task automatic predict_motion(input motion_req_type q, output motion_rsp_type e);
      logic [63:0] t, r, s;
      t = {16'd0, q.time_ns};
      case (q.action)
         ttm_pkg::ACT_COMMAND: begin
            go_bit = q.go;
            rev_bit = q.reverse;
            if (!q.go) begin
               pend_accel = 1'b0;
               begin_stop(t, {32'd0, stop_ramp});
            end else if (mot == ttm_pkg::MOT_STOPPED) begin
               begin_run(t, q.reverse, {32'd0, start_ramp});
            end else if (mot == ttm_pkg::MOT_DECEL) begin
               if (q.reverse == dir_rev) begin
                  pend_accel = 1'b0;
                  begin_run(t, q.reverse, {32'd0, start_ramp});
               end else arm_turn(q.reverse);
            end else if (q.reverse != dir_rev) begin
               begin_stop(t, {32'd0, stop_ramp});
               arm_turn(q.reverse);
            end
         end
         ttm_pkg::ACT_EZ_STOP: begin
            go_bit = 1'b0;
            pend_accel = 1'b0;
            begin_stop(t, {32'd0, stop_ramp});
         end
         ttm_pkg::ACT_END_SEG: begin
            r = nz(ramp_len);
            if (mot == ttm_pkg::MOT_ACCEL) begin
               seg_pos = shift_pos(seg_pos, r / 64'd2, dir_rev);
               seg_time = (seg_time + r) & MASK48;
               mot = ttm_pkg::MOT_CRUISE;
            end else if (mot == ttm_pkg::MOT_DECEL) begin
               if (pend_accel) begin
                  pend_accel = 1'b0;
                  mot = ttm_pkg::MOT_ACCEL;
                  dir_rev = pend_rev;
                  ramp_len = nz(pend_ramp);
               end else mot = ttm_pkg::MOT_STOPPED;
            end
         end
         ttm_pkg::ACT_PARK: begin
            mot = ttm_pkg::MOT_STOPPED;
            seg_pos = {16'd0, q.park_position};
            seg_time = 64'd0;
            go_bit = 1'b0;
            rev_bit = 1'b0;
            pend_accel = 1'b0;
         end
         default: ;
      endcase
      if (mot == ttm_pkg::MOT_ACCEL) s = (seg_time + nz(ramp_len)) & MASK48;
      else if (mot == ttm_pkg::MOT_DECEL) s = seg_time;
      else s = {16'd0, MASK48};
      e.segment_end = s[47:0];
      s = pos_at(t);
      e.position = s[47:0];
      e.segment_open = (mot == ttm_pkg::MOT_STOPPED || mot == ttm_pkg::MOT_CRUISE);
      e.motion_state = mot;
      e.moving_reverse = dir_rev;
      e.go_latched = go_bit;
      e.rev_latched = rev_bit;
      e.turn_pending = pend_accel;
   endtask

   // driver: one transaction at a time from the pending queue
   always @(posedge clock) begin
      motion_req_type q;
      motion_rsp_type e;
      if (!reset) begin
         if (req_valid && req_ready) begin
            q = {req_action, req_time_ns, req_go, req_reverse, req_park_position};
            predict_motion(q, e);
            expected_rsps.push_back(e);
         end
         if (!req_valid || req_ready) begin
            if (pending_reqs.size() != 0 && !hold_sender &&
                $urandom_range(99) >= send_idle_pct) begin
               q = pending_reqs.pop_front();
               req_valid <= 1'b1;
               {req_action, req_time_ns, req_go, req_reverse, req_park_position} <= q;
            end else req_valid <= 1'b0;
         end
         busy <= (pending_reqs.size() != 0) || req_valid;
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // monitor: compare each result with the oldest expectation
   always @(posedge clock) begin
      motion_rsp_type a, e;
      if (!reset && rsp_valid && rsp_ready) begin
         a = {rsp_position, rsp_segment_end, rsp_segment_open, rsp_motion_state,
              rsp_moving_reverse, rsp_go_latched, rsp_rev_latched, rsp_turn_pending};
         rsp_count++;
         if (expected_rsps.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result %h", a);
         end else begin
            e = expected_rsps.pop_front();
            if (a !== e) begin
               errors++;
               if (errors <= 10) begin
                  $display("mismatch #%0d: exp pos %h seg %h o%b m%0d r%b g%b v%b t%b",
                     rsp_count, e.position, e.segment_end, e.segment_open,
                     e.motion_state, e.moving_reverse, e.go_latched, e.rev_latched,
                     e.turn_pending);
                  $display("   got pos %h seg %h o%b m%0d r%b g%b v%b t%b",
                     a.position, a.segment_end, a.segment_open, a.motion_state,
                     a.moving_reverse, a.go_latched, a.rev_latched, a.turn_pending);
               end
            end
         end
      end
   end

   function automatic motion_req_type make_req(logic [2:0] act, logic [47:0] t, logic g,
                                               logic rv, logic [47:0] pk);
      motion_req_type q;
      q.action = act; q.time_ns = t; q.go = g; q.reverse = rv; q.park_position = pk;
      return q;
   endfunction

   task automatic wait_drained();
      do @(posedge clock); while (busy || pending_reqs.size() != 0 || req_valid ||
                                  expected_rsps.size() != 0);
      repeat (500) @(posedge clock);
   endtask

   task automatic write_ramp(logic [1:0] idx, logic [31:0] v);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == ttm_pkg::CSR_STOP_RAMP) stop_ramp = v;
      else if (idx == ttm_pkg::CSR_START_RAMP) start_ramp = v;
      else turn_ramp = v;
      cfg_writes++;
   endtask

   function automatic logic [47:0] rand48();
      logic [63:0] w;
      w = {$urandom(), $urandom()};
      return w[47:0];
   endfunction

   // random motion: mostly plausible sequences with times moving forward
   task automatic queue_random(int n, logic [31:0] tmax);
      logic [47:0] t;
      int k;
      t = rand48();
      for (int i = 0; i < n; i++) begin
         k = $urandom_range(99);
         t = t + $urandom_range(tmax);
         if (k < 5) t = rand48();
         if (k < 30) pending_reqs.push_back(make_req(ttm_pkg::ACT_COMMAND, t,
                        $urandom_range(9) != 0, 1'($urandom_range(1)), rand48()));
         else if (k < 50) pending_reqs.push_back(make_req(ttm_pkg::ACT_END_SEG, t,
                        1'($urandom_range(1)), 1'($urandom_range(1)), rand48()));
         else if (k < 60) pending_reqs.push_back(make_req(ttm_pkg::ACT_EZ_STOP, t,
                        1'($urandom_range(1)), 1'($urandom_range(1)), rand48()));
         else if (k < 66) pending_reqs.push_back(make_req(ttm_pkg::ACT_PARK, t,
                        1'($urandom_range(1)), 1'($urandom_range(1)), rand48()));
         else if (k < 72) pending_reqs.push_back(make_req(3'($urandom_range(7)), rand48(),
                        1'($urandom_range(1)), 1'($urandom_range(1)), rand48()));
         else pending_reqs.push_back(make_req(ttm_pkg::ACT_QUERY,
                        t - $urandom_range(tmax / 4),
                        1'($urandom_range(1)), 1'($urandom_range(1)), rand48()));
      end
   endtask

   initial begin
      stop_ramp = ttm_pkg::STOP_RAMP_RST;
      start_ramp = ttm_pkg::START_RAMP_RST;
      turn_ramp = ttm_pkg::TURN_RAMP_RST;
      mot = ttm_pkg::MOT_STOPPED; dir_rev = 1'b0; pend_accel = 1'b0; pend_rev = 1'b0;
      go_bit = 1'b0; rev_bit = 1'b0; seg_time = 64'd0; seg_pos = 64'd0;
      ramp_len = 64'd0; pend_ramp = 64'd0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset ramps, start, cruise, reverse turnaround, stops, park
      pending_reqs.push_back(make_req(ttm_pkg::ACT_QUERY, 48'd0, 1'b0, 1'b0, 48'd0));
      pending_reqs.push_back(make_req(ttm_pkg::ACT_COMMAND, 48'd1000, 1'b1, 1'b0, 48'd0));
      pending_reqs.push_back(make_req(ttm_pkg::ACT_QUERY, 48'd50001000, 1'b0, 1'b0, 48'd0));
      pending_reqs.push_back(make_req(ttm_pkg::ACT_QUERY, 48'd500, 1'b0, 1'b0, 48'd0));
      pending_reqs.push_back(make_req(ttm_pkg::ACT_END_SEG, 48'd200001000, 1'b0, 1'b0,
                                      48'd0));
      pending_reqs.push_back(make_req(ttm_pkg::ACT_QUERY, 48'd300000000, 1'b0, 1'b0,
                                      48'd0));
      pending_reqs.push_back(make_req(ttm_pkg::ACT_COMMAND, 48'd300000000, 1'b1, 1'b1,
                                      48'd0));
      pending_reqs.push_back(make_req(ttm_pkg::ACT_COMMAND, 48'd310000000, 1'b1, 1'b1,
                                      48'd0));
      pending_reqs.push_back(make_req(ttm_pkg::ACT_END_SEG, 48'd450000000, 1'b0, 1'b0,
                                      48'd0));
      pending_reqs.push_back(make_req(ttm_pkg::ACT_QUERY, 48'd500000000, 1'b0, 1'b0,
                                      48'd0));
      pending_reqs.push_back(make_req(ttm_pkg::ACT_COMMAND, 48'd520000000, 1'b0, 1'b1,
                                      48'd0));
      pending_reqs.push_back(make_req(ttm_pkg::ACT_COMMAND, 48'd530000000, 1'b1, 1'b1,
                                      48'd0));
      pending_reqs.push_back(make_req(ttm_pkg::ACT_EZ_STOP, 48'd540000000, 1'b1, 1'b1,
                                      48'd0));
      pending_reqs.push_back(make_req(ttm_pkg::ACT_END_SEG, 48'd900000000, 1'b0, 1'b0,
                                      48'd0));
      pending_reqs.push_back(make_req(ttm_pkg::ACT_END_SEG, 48'd900000000, 1'b0, 1'b0,
                                      48'd0));
      pending_reqs.push_back(make_req(3'd7, MASK48, 1'b1, 1'b1, 48'd0));
      pending_reqs.push_back(make_req(3'd5, 48'd0, 1'b0, 1'b0, 48'd0));
      pending_reqs.push_back(make_req(ttm_pkg::ACT_PARK, MASK48, 1'b1, 1'b1,
                                      48'h7FFF_FFFF_FFFF));
      pending_reqs.push_back(make_req(ttm_pkg::ACT_COMMAND, MASK48 - 48'd10, 1'b1, 1'b0,
                                      48'd0));
      pending_reqs.push_back(make_req(ttm_pkg::ACT_QUERY, 48'd100, 1'b0, 1'b0, 48'd0));
      pending_reqs.push_back(make_req(ttm_pkg::ACT_PARK, 48'd0, 1'b0, 1'b0,
                                      48'h8000_0000_0000));
      pending_reqs.push_back(make_req(ttm_pkg::ACT_COMMAND, 48'd5, 1'b1, 1'b1, 48'd0));
      pending_reqs.push_back(make_req(ttm_pkg::ACT_QUERY, 48'd7, 1'b0, 1'b0, 48'd0));
      wait_drained();

      // zero and tiny ramps
      write_ramp(ttm_pkg::CSR_STOP_RAMP, 32'd0);
      write_ramp(ttm_pkg::CSR_START_RAMP, 32'd1);
      write_ramp(ttm_pkg::CSR_TURN_RAMP, 32'd0);
      queue_random(150, 32'd8);
      wait_drained();

      // the largest ramps
      write_ramp(ttm_pkg::CSR_STOP_RAMP, 32'hFFFF_FFFF);
      write_ramp(ttm_pkg::CSR_START_RAMP, 32'hFFFF_FFFF);
      write_ramp(ttm_pkg::CSR_TURN_RAMP, 32'hFFFF_FFFF);
      queue_random(150, 32'hFFFF_FFFF);
      // part way in, hold the sender until every result is back, then resume
      repeat (3000) @(posedge clock);
      hold_sender <= 1'b1;
      do @(posedge clock); while (req_valid || expected_rsps.size() != 0);
      repeat (40) @(posedge clock);
      hold_sender <= 1'b0;
      wait_drained();

      // random ramp settings
      send_idle_pct = 49; recv_idle_pct = 35;
      write_ramp(ttm_pkg::CSR_STOP_RAMP, $urandom());
      write_ramp(ttm_pkg::CSR_START_RAMP, $urandom_range(1000));
      write_ramp(ttm_pkg::CSR_TURN_RAMP, $urandom_range(100000));
      queue_random(250, 32'd200000);
      wait_drained();

      send_idle_pct = 0; recv_idle_pct = 0;
      write_ramp(ttm_pkg::CSR_STOP_RAMP, ttm_pkg::STOP_RAMP_RST);
      write_ramp(ttm_pkg::CSR_START_RAMP, ttm_pkg::START_RAMP_RST);
      write_ramp(ttm_pkg::CSR_TURN_RAMP, ttm_pkg::TURN_RAMP_RST);
      queue_random(250, 32'd300000000);
      wait_drained();

      $display("Covered %0d motion results over %0d ramp register writes,", rsp_count,
               cfg_writes);
      $display("with zero, tiny, random and full-scale ramps and random handshake gaps.");
      if (errors == 0) $display("Testbench completed without errors");
      else begin
         $display("%0d mismatches", errors);
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("Timeout");
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

`default_nettype wire
